// ----- design/ttb_pkg.sv -----
// Package for the tickless timer bank: shared types, constants and helpers.
// No dependencies; used by every module of the block but ttb_ram.
`timescale 1ns / 1ps

package ttb_pkg;

	localparam int TTB_NUM_TIMERS = 8;
	localparam int TTB_KIND_W     = 2;
	localparam int TTB_ID_W       = 3;
	localparam int TTB_CNT_W      = 32;
	localparam int TTB_ARM_W      = 8;
	localparam logic [TTB_ARM_W-1:0] TTB_MAX_ARM = 8'hFF;

	localparam logic [TTB_KIND_W-1:0] KIND_CMP   = 2'd0;
	localparam logic [TTB_KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [TTB_KIND_W-1:0] KIND_STOP  = 2'd2;

	typedef enum logic [2:0] {
		OP_CMP,
		OP_START,
		OP_STOP,
		OP_NOP,
		OP_REJ
	} ttb_op_t;

	typedef struct packed {
		ttb_op_t                op;
		logic [TTB_ID_W-1:0]    id;
		logic [TTB_CNT_W-1:0]   ival;
		logic                   rep;
		logic [TTB_ARM_W-1:0]   ttc;
	} ttb_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_EX,
		ST_WALK_RD,
		ST_WALK_EX,
		ST_STOP_RD,
		ST_STOP_EX,
		ST_FINAL
	} ttb_state_t;

	// Clamp a count to the compare range.
	function automatic logic [TTB_ARM_W-1:0] ttb_sat_arm(input logic [TTB_CNT_W-1:0] v);
		if (v >= {{(TTB_CNT_W-TTB_ARM_W){1'b0}}, TTB_MAX_ARM}) begin
			return TTB_MAX_ARM;
		end
		return v[TTB_ARM_W-1:0];
	endfunction

endpackage

// ----- design/ttb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ttb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/ttb_front.sv -----
// Front end: accept input transactions, decode them into commands, queue them.
// Depends on ttb_pkg.
`timescale 1ns / 1ps

module ttb_front #(
	parameter int NUM_TIMERS = ttb_pkg::TTB_NUM_TIMERS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ttb_pkg::TTB_KIND_W-1:0]  kind,
	input  logic [ttb_pkg::TTB_ID_W-1:0]    timer_id,
	input  logic [ttb_pkg::TTB_CNT_W-1:0]   interval,
	input  logic                            repeat_req,
	input  logic [ttb_pkg::TTB_ARM_W-1:0]   ticks_to_compare,
	output logic                            cmd_valid,
	output ttb_pkg::ttb_cmd_t               cmd,
	input  logic                            cmd_pop
);
	import ttb_pkg::*;

	ttb_cmd_t  dec;
	ttb_cmd_t  fifo_q [2];
	logic      wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic      push, in_range;

	assign in_range = (32'(timer_id) < NUM_TIMERS);

	always_comb begin
		dec.id   = timer_id;
		dec.ival = (interval == '0) ? TTB_CNT_W'(1) : interval;
		dec.rep  = repeat_req;
		dec.ttc  = ticks_to_compare;
		unique case (kind)
			KIND_CMP:   dec.op = OP_CMP;
			KIND_START: dec.op = in_range ? OP_START : OP_REJ;
			KIND_STOP:  dec.op = in_range ? OP_STOP : OP_NOP;
			default:    dec.op = OP_NOP;
		endcase
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

// ----- design/ttb_back.sv -----
// Back end: sequencer that carries out commands over the timer slots.
// Depends on ttb_pkg and ttb_ram.
`timescale 1ns / 1ps

module ttb_back #(
	parameter int NUM_TIMERS = ttb_pkg::TTB_NUM_TIMERS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  ttb_pkg::ttb_cmd_t              cmd,
	output logic                           cmd_pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           fired,
	output logic [ttb_pkg::TTB_ID_W-1:0]   fired_timer,
	output logic                           accepted,
	output logic [ttb_pkg::TTB_ARM_W-1:0]  cmp_interval,
	output logic                           compare_enable,
	output logic                           last
);
	import ttb_pkg::*;

	localparam int IDW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [IDW-1:0] LAST_IDX = IDW'(NUM_TIMERS - 1);

	ttb_state_t state_q, state_d;
	logic [NUM_TIMERS-1:0] run_q, run_d, rep_q, rep_d;
	logic [TTB_ARM_W-1:0]  armed_q, armed_d, delta_q, delta_d;
	logic [IDW-1:0]        idx_q, idx_d, sid_q, sid_d;
	logic [TTB_CNT_W-1:0]  c_q, c_d, best_q, best_d;
	logic                  have_q, have_d, early_q, early_d, acc_q, acc_d;

	logic                  rem_we, rel_we;
	logic [IDW-1:0]        wa;
	logic [TTB_CNT_W-1:0]  rem_wd, rem_rd, rel_rd;

	logic                  out_free, emit;
	logic                  o_fired, o_acc, o_en, o_last;
	logic [TTB_ID_W-1:0]   o_tmr;
	logic [TTB_ARM_W-1:0]  o_nxt;

	logic [IDW-1:0]        cid;
	logic [TTB_ARM_W-1:0]  el;
	logic [TTB_CNT_W:0]    sum;
	logic [TTB_CNT_W-1:0]  nv;
	logic                  fire, stays, early_n;

	ttb_ram #(.WIDTH(TTB_CNT_W), .DEPTH(NUM_TIMERS)) u_rem (
		.clk(clk), .we(rem_we), .waddr(wa), .wdata(rem_wd), .raddr(idx_q), .rdata(rem_rd)
	);
	ttb_ram #(.WIDTH(TTB_CNT_W), .DEPTH(NUM_TIMERS)) u_rel (
		.clk(clk), .we(rel_we), .waddr(wa), .wdata(cmd.ival), .raddr(idx_q), .rdata(rel_rd)
	);

	assign out_free = !out_valid || !out_stall;
	assign cid      = IDW'(cmd.id);
	assign el       = (armed_q > cmd.ttc) ? (armed_q - cmd.ttc) : '0;
	assign sum      = {1'b0, cmd.ival} + (TTB_CNT_W+1)'(el);

	always_comb begin
		state_d = state_q;
		run_d   = run_q;
		rep_d   = rep_q;
		armed_d = armed_q;
		delta_d = delta_q;
		idx_d   = idx_q;
		sid_d   = sid_q;
		c_d     = c_q;
		best_d  = best_q;
		have_d  = have_q;
		early_d = early_q;
		acc_d   = acc_q;
		rem_we  = 1'b0;
		rel_we  = 1'b0;
		wa      = idx_q;
		rem_wd  = '0;
		cmd_pop = 1'b0;
		emit    = 1'b0;
		o_fired = 1'b0;
		o_tmr   = '0;
		o_acc   = 1'b1;
		o_nxt   = '0;
		o_en    = 1'b0;
		o_last  = 1'b0;
		fire    = 1'b0;
		stays   = 1'b0;
		nv      = rem_rd;
		early_n = early_q;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					acc_d   = 1'b1;
					unique case (cmd.op)
						OP_CMP: begin
							if (|run_q) begin
								delta_d = armed_q;
								idx_d   = '0;
								have_d  = 1'b0;
								state_d = ST_WALK_RD;
							end else begin
								state_d = ST_FINAL;
							end
						end
						OP_START: begin
							if (run_q[cid]) begin
								acc_d   = 1'b0;
								state_d = ST_FINAL;
							end else begin
								rel_we     = 1'b1;
								rem_we     = 1'b1;
								wa         = cid;
								rep_d[cid] = cmd.rep;
								run_d[cid] = 1'b1;
								if (!(|run_q)) begin
									rem_wd  = cmd.ival;
									armed_d = ttb_sat_arm(cmd.ival);
									state_d = ST_FINAL;
								end else begin
									// Fold elapsed ticks in; saturate on carry.
									rem_wd  = sum[TTB_CNT_W] ? '1 : sum[TTB_CNT_W-1:0];
									c_d     = rem_wd;
									delta_d = el;
									sid_d   = cid;
									early_d = 1'b1;
									idx_d   = '0;
									state_d = ST_SCAN_RD;
								end
							end
						end
						OP_STOP: begin
							if (run_q[cid]) begin
								idx_d   = cid;
								state_d = ST_STOP_RD;
							end else begin
								state_d = ST_FINAL;
							end
						end
						OP_REJ: begin
							acc_d   = 1'b0;
							state_d = ST_FINAL;
						end
						default: begin
							state_d = ST_FINAL;
						end
					endcase
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_EX;
			ST_SCAN_EX: begin
				if (idx_q != sid_q && run_q[idx_q] && rem_rd < c_q) begin
					early_n = 1'b0;
				end
				early_d = early_n;
				if (idx_q == LAST_IDX) begin
					if (early_n && c_q < TTB_CNT_W'(armed_q)) begin
						idx_d   = '0;
						have_d  = 1'b0;
						state_d = ST_WALK_RD;
					end else begin
						state_d = ST_FINAL;
					end
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_WALK_RD: state_d = ST_WALK_EX;
			ST_WALK_EX: begin
				fire = run_q[idx_q] && (delta_q != '0) && (rem_rd <= TTB_CNT_W'(delta_q));
				if (!(fire && !out_free)) begin
					if (run_q[idx_q]) begin
						if (fire) begin
							nv = '0;
						end else if (delta_q != '0) begin
							nv = rem_rd - TTB_CNT_W'(delta_q);
						end
						stays = 1'b1;
						if (nv == '0) begin
							nv    = rel_rd;
							stays = rep_q[idx_q];
							run_d[idx_q] = rep_q[idx_q];
						end
						rem_we = 1'b1;
						rem_wd = nv;
						if (stays && (!have_q || nv < best_q)) begin
							best_d = nv;
							have_d = 1'b1;
						end
					end
					if (fire) begin
						emit    = 1'b1;
						o_fired = 1'b1;
						o_tmr   = TTB_ID_W'(idx_q);
					end
					if (idx_q == LAST_IDX) begin
						armed_d = have_d ? ttb_sat_arm(best_d) : '0;
						state_d = ST_FINAL;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = ST_WALK_RD;
					end
				end
			end
			ST_STOP_RD: state_d = ST_STOP_EX;
			ST_STOP_EX: begin
				rem_we       = 1'b1;
				rem_wd       = rel_rd;
				run_d[idx_q] = 1'b0;
				if ((run_q & ~(NUM_TIMERS'(1) << idx_q)) == '0) begin
					armed_d = '0;
				end
				state_d = ST_FINAL;
			end
			ST_FINAL: begin
				if (out_free) begin
					emit    = 1'b1;
					o_acc   = acc_q;
					o_en    = |run_q;
					o_nxt   = o_en ? armed_q : '0;
					o_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			run_q     <= '0;
			rep_q     <= '0;
			armed_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			run_q   <= run_d;
			rep_q   <= rep_d;
			armed_q <= armed_d;
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		delta_q <= delta_d;
		idx_q   <= idx_d;
		sid_q   <= sid_d;
		c_q     <= c_d;
		best_q  <= best_d;
		have_q  <= have_d;
		early_q <= early_d;
		acc_q   <= acc_d;
		if (emit) begin
			fired          <= o_fired;
			fired_timer    <= o_tmr;
			accepted       <= o_acc;
			cmp_interval   <= o_nxt;
			compare_enable <= o_en;
			last           <= o_last;
		end
	end

endmodule

// ----- design/tickless_timer_bank_top.sv -----
// Top level of the tickless timer bank: front decoder/queue plus back sequencer.
// Depends on ttb_pkg, ttb_front, ttb_back (and ttb_ram through ttb_back).
`timescale 1ns / 1ps

// A bank of NUM_TIMERS one-shot or periodic timers sharing one compare
// interrupt. Each input transaction is a compare match, a start or a stop;
// it yields zero or more fired reports (ascending slot order) followed by one
// final result with last=1 that carries the compare interval to program and
// the compare enable. The front queue holds two decoded transactions so input
// is taken while the back end works. In the back end a compare, when any timer
// runs, walks every slot (RAM read, then update); a start onto a bank that
// already runs scans all slots for the earliest count and, if it re-arms,
// walks them again; a stop reads the slot, then restores its reload count. Fired
// reports wait on out_stall, which pauses the walk. Remaining and reload
// counts live in single-port-read RAMs; that one read port sets the rate.
module tickless_timer_bank_top #(
	parameter int NUM_TIMERS = ttb_pkg::TTB_NUM_TIMERS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ttb_pkg::TTB_KIND_W-1:0]  kind,
	input  logic [ttb_pkg::TTB_ID_W-1:0]    timer_id,
	input  logic [ttb_pkg::TTB_CNT_W-1:0]   interval,
	input  logic                            repeat_req,
	input  logic [ttb_pkg::TTB_ARM_W-1:0]   ticks_to_compare,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            fired,
	output logic [ttb_pkg::TTB_ID_W-1:0]    fired_timer,
	output logic                            accepted,
	output logic [ttb_pkg::TTB_ARM_W-1:0]   cmp_interval,
	output logic                            compare_enable,
	output logic                            last
);
	import ttb_pkg::*;

	logic     cmd_valid, cmd_pop;
	ttb_cmd_t cmd;

	// Decode and queue incoming transactions.
	ttb_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .timer_id(timer_id), .interval(interval),
		.repeat_req(repeat_req), .ticks_to_compare(ticks_to_compare),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	// Execute commands against timer state and drive the result register.
	ttb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.fired(fired), .fired_timer(fired_timer), .accepted(accepted),
		.cmp_interval(cmp_interval), .compare_enable(compare_enable), .last(last)
	);

endmodule

// ----- design/ttb_checker.sv -----
// Port-level checker for the tickless timer bank, bound to the top level.
// Depends on ttb_pkg and tickless_timer_bank_top.
`timescale 1ns / 1ps

module ttb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            fired,
	input logic [ttb_pkg::TTB_ID_W-1:0]    fired_timer,
	input logic                            accepted,
	input logic [ttb_pkg::TTB_ARM_W-1:0]   cmp_interval,
	input logic                            compare_enable,
	input logic                            last
);

	// Hold a stalled result.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fired) && $stable(last)
			&& $stable(fired_timer) && $stable(cmp_interval))
		else $error("stalled result changed");

	a_fired_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired |-> accepted && !last && !compare_enable && cmp_interval == '0)
		else $error("fired report carries final-result fields");

	a_final_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !fired && fired_timer == '0)
		else $error("final result marked as fired");

	a_arm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> (compare_enable == (cmp_interval != '0)))
		else $error("compare interval disagrees with enable");

endmodule

bind tickless_timer_bank_top ttb_checker u_ttb_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.fired(fired), .fired_timer(fired_timer), .accepted(accepted),
	.cmp_interval(cmp_interval), .compare_enable(compare_enable), .last(last)
);

// ----- bench/tickless_timer_bank_top_tb.sv -----
// Self-checking bench for tickless_timer_bank_top: directed table, then random traffic,
// every result checked against an in-bench timer bank model.
// Depends on ttb_pkg and the tickless_timer_bank_top RTL.
`timescale 1ns / 1ps

module tickless_timer_bank_top_tb;
	import ttb_pkg::*;

	localparam int NT = TTB_NUM_TIMERS;
	localparam logic [TTB_KIND_W-1:0] KIND_BAD = 2'd3;

	typedef struct packed {
		logic [TTB_KIND_W-1:0] kind;
		logic [TTB_ID_W-1:0]   id;
		logic [TTB_CNT_W-1:0]  ival;
		logic                  rep;
		logic [TTB_ARM_W-1:0]  ttc;
	} timer_cmd_t;

	typedef struct packed {
		logic                 fired;
		logic [TTB_ID_W-1:0]  idx;
		logic                 acc;
		logic [TTB_ARM_W-1:0] nxt;
		logic                 en;
		logic                 last;
	} timer_res_t;

	// One directed row; chk marks a hand-typed final result.
	typedef struct packed {
		timer_cmd_t cmd;
		logic       chk;
		timer_res_t res;
	} dir_row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [TTB_KIND_W-1:0] kind;
	logic [TTB_ID_W-1:0] timer_id;
	logic [TTB_CNT_W-1:0] interval;
	logic repeat_req;
	logic [TTB_ARM_W-1:0] ticks_to_compare;
	logic fired, accepted, compare_enable, last;
	logic [TTB_ID_W-1:0] fired_timer;
	logic [TTB_ARM_W-1:0] cmp_interval;

	tickless_timer_bank_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .timer_id(timer_id), .interval(interval),
		.repeat_req(repeat_req), .ticks_to_compare(ticks_to_compare),
		.out_valid(out_valid), .out_stall(out_stall),
		.fired(fired), .fired_timer(fired_timer), .accepted(accepted),
		.cmp_interval(cmp_interval), .compare_enable(compare_enable), .last(last)
	);

	// Bank model state.
	logic                 bank_run [NT];
	logic                 bank_rep [NT];
	logic [TTB_CNT_W-1:0] bank_reload [NT];
	logic [TTB_CNT_W-1:0] bank_left [NT];
	logic [TTB_ARM_W-1:0] bank_armed;

	timer_res_t pending_results[$];
	// One entry per accepted transaction, consumed with its final result.
	timer_res_t typed_finals[$];
	logic       typed_chk[$];
	int mismatches, results_seen, fires_seen, items_sent;
	int idle_pct_in, idle_pct_out;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic bank_any();
		foreach (bank_run[i]) if (bank_run[i]) return 1'b1;
		return 1'b0;
	endfunction

	// Advance every running count by delta, report expiries, reload and re-arm.
	function automatic void bank_advance(logic [TTB_ARM_W-1:0] delta);
		logic have;
		logic [TTB_CNT_W-1:0] best;
		timer_res_t r;
		have = 0;
		best = '0;
		if (!bank_any()) return;
		if (delta != 0) begin
			for (int i = 0; i < NT; i++) begin
				if (!bank_run[i]) continue;
				if (bank_left[i] <= delta) begin
					bank_left[i] = '0;
					r = '{fired: 1'b1, idx: i[TTB_ID_W-1:0], acc: 1'b1, nxt: '0, en: 1'b0,
						last: 1'b0};
					pending_results.push_back(r);
				end else begin
					bank_left[i] -= delta;
				end
			end
		end
		for (int i = 0; i < NT; i++) begin
			if (bank_run[i] && bank_left[i] == 0) begin
				bank_left[i] = bank_reload[i];
				if (!bank_rep[i]) bank_run[i] = 1'b0;
			end
		end
		for (int i = 0; i < NT; i++) begin
			if (bank_run[i] && (!have || bank_left[i] < best)) begin
				best = bank_left[i];
				have = 1'b1;
			end
		end
		bank_armed = have ? (best >= 32'hFF ? TTB_MAX_ARM : best[TTB_ARM_W-1:0]) : '0;
	endfunction

	// Apply one transaction to the model and queue the results it causes.
	function automatic void bank_apply(timer_cmd_t c);
		logic acc, others, earliest;
		logic [TTB_CNT_W-1:0] iv, cnt;
		logic [TTB_ARM_W-1:0] el;
		timer_res_t r;
		acc = 1'b1;
		case (c.kind)
			KIND_CMP: bank_advance(bank_armed);
			KIND_START: begin
				if (bank_run[c.id]) begin
					acc = 1'b0;
				end else begin
					others = bank_any();
					iv = (c.ival == 0) ? 32'd1 : c.ival;
					bank_reload[c.id] = iv;
					bank_left[c.id] = iv;
					bank_rep[c.id] = c.rep;
					bank_run[c.id] = 1'b1;
					if (!others) begin
						bank_armed = '0;
						bank_advance('0);
					end else begin
						el = (bank_armed > c.ttc) ? bank_armed - c.ttc : '0;
						cnt = iv + TTB_CNT_W'(el);
						if (cnt < iv) cnt = '1;
						bank_left[c.id] = cnt;
						earliest = 1'b1;
						for (int i = 0; i < NT; i++)
							if (i != c.id && bank_run[i] && bank_left[i] < cnt)
								earliest = 1'b0;
						if (earliest && cnt < bank_armed) bank_advance(el);
					end
				end
			end
			KIND_STOP: begin
				if (bank_run[c.id]) begin
					bank_run[c.id] = 1'b0;
					bank_left[c.id] = bank_reload[c.id];
					if (!bank_any()) bank_armed = '0;
				end
			end
			default: ;
		endcase
		r = '{fired: 1'b0, idx: '0, acc: acc, nxt: bank_any() ? bank_armed : '0,
			en: bank_any(), last: 1'b1};
		pending_results.push_back(r);
	endfunction

	// Hold the transaction until accepted; advance the model on acceptance.
	task automatic send_cmd(timer_cmd_t c, logic chk = 1'b0, timer_res_t res = '0);
		while ($urandom_range(99) < idle_pct_in) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= c.kind;
		timer_id <= c.id;
		interval <= c.ival;
		repeat_req <= c.rep;
		ticks_to_compare <= c.ttc;
		do @(posedge clk); while (in_stall);
		bank_apply(c);
		typed_chk.push_back(chk);
		typed_finals.push_back(res);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain(int settle);
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (settle) @(negedge clk);
	endtask

	// Receiver: randomized stall, check every accepted result.
	always @(negedge clk) begin
		out_stall <= arst_n ? ($urandom_range(99) < idle_pct_out) : 1'b0;
	end

	always @(posedge clk) begin
		timer_res_t got, want, typed_res;
		logic typed_on;
		if (arst_n && out_valid && !out_stall) begin
			got = '{fired: fired, idx: fired_timer, acc: accepted, nxt: cmp_interval,
				en: compare_enable, last: last};
			results_seen++;
			if (fired) fires_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = pending_results.pop_front();
				if (want.last && typed_chk.size() != 0) begin
					typed_on = typed_chk.pop_front();
					typed_res = typed_finals.pop_front();
					if (typed_on && typed_res != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("table row disagrees: typed %p model %p",
								typed_res, want);
					end
				end
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// Directed table: extremes, every kind, rejects, wrap, saturation, expiries.
	localparam timer_res_t FIN_IDLE = '{1'b0, 3'd0, 1'b1, 8'd0, 1'b0, 1'b1};
	dir_row_t dir_table [] = '{
		'{'{KIND_CMP,   3'd0, 32'd0,        1'b0, 8'd0},   1'b1, FIN_IDLE},
		'{'{KIND_STOP,  3'd7, 32'd0,        1'b0, 8'd0},   1'b1, FIN_IDLE},
		'{'{KIND_BAD,   3'd5, 32'hFFFFFFFF, 1'b1, 8'hFF},  1'b1, FIN_IDLE},
		'{'{KIND_START, 3'd0, 32'd0,        1'b0, 8'd0},   1'b1,
			'{1'b0, 3'd0, 1'b1, 8'd1, 1'b1, 1'b1}},
		'{'{KIND_CMP,   3'd0, 32'd0,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_START, 3'd7, 32'hFFFFFFFF, 1'b1, 8'd0},   1'b1,
			'{1'b0, 3'd0, 1'b1, 8'hFF, 1'b1, 1'b1}},
		'{'{KIND_START, 3'd7, 32'd5,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_START, 3'd3, 32'hFFFFFFFE, 1'b0, 8'd10},  1'b0, '0},
		'{'{KIND_START, 3'd1, 32'd3,        1'b1, 8'hFF},  1'b0, '0},
		'{'{KIND_START, 3'd2, 32'd3,        1'b0, 8'd3},   1'b0, '0},
		'{'{KIND_START, 3'd4, 32'd3,        1'b1, 8'd1},   1'b0, '0},
		'{'{KIND_CMP,   3'd0, 32'd0,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_CMP,   3'd0, 32'd0,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_STOP,  3'd1, 32'd0,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_STOP,  3'd1, 32'd0,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_START, 3'd5, 32'd200,      1'b1, 8'd0},   1'b0, '0},
		'{'{KIND_START, 3'd6, 32'd1,        1'b0, 8'd200}, 1'b0, '0},
		'{'{KIND_CMP,   3'd0, 32'd0,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_STOP,  3'd3, 32'd0,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_STOP,  3'd4, 32'd0,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_STOP,  3'd5, 32'd0,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_STOP,  3'd6, 32'd0,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_STOP,  3'd7, 32'd0,        1'b0, 8'd0},   1'b0, '0},
		'{'{KIND_STOP,  3'd0, 32'd0,        1'b0, 8'd0},   1'b1, FIN_IDLE}
	};

	// Random transaction: mostly starts and compares with short intervals so
	// timers expire often, occasional huge counts and stray kinds.
	function automatic timer_cmd_t rand_cmd();
		timer_cmd_t c;
		int p;
		p = $urandom_range(99);
		c.kind = (p < 40) ? KIND_START : (p < 75) ? KIND_CMP : (p < 95) ? KIND_STOP : KIND_BAD;
		c.id = TTB_ID_W'($urandom_range(NT - 1));
		p = $urandom_range(99);
		c.ival = (p < 70) ? $urandom_range(1, 300) : (p < 85) ? $urandom_range(0, 8) : $urandom();
		c.rep = 1'($urandom_range(1));
		c.ttc = TTB_ARM_W'($urandom_range(255));
		return c;
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		timer_id = '0;
		interval = '0;
		repeat_req = 1'b0;
		ticks_to_compare = '0;
		idle_pct_in = 0;
		idle_pct_out = 0;
		mismatches = 0;
		results_seen = 0;
		fires_seen = 0;
		items_sent = 0;
		foreach (bank_run[i]) begin
			bank_run[i] = 1'b0;
			bank_rep[i] = 1'b0;
			bank_reload[i] = '0;
			bank_left[i] = '0;
		end
		bank_armed = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows, no idling; typed finals travel with each row.
		foreach (dir_table[r]) begin
			send_cmd(dir_table[r].cmd, dir_table[r].chk, dir_table[r].res);
		end
		// Pause until every expected result is back.
		drain(40);

		// Random phases: none, sender idle, receiver stall, both.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct_in = (ph == 1 || ph == 3) ? ((ph == 3) ? 9 : 53) : 0;
			idle_pct_out = (ph == 2 || ph == 3) ? ((ph == 3) ? 9 : 53) : 0;
			repeat (19) send_cmd(rand_cmd());
		end
		idle_pct_out = 0;
		drain(40);

		$display("sent %0d transactions, checked %0d results (%0d expiries)",
			items_sent, results_seen, fires_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches,
				pending_results.size());
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule
